// ----- sv/plte_pkg.sv -----
// package for the process table lifecycle engine
// types, codes and constants shared by every module of the block; no dependencies
`default_nettype none

package plte_pkg;

    localparam int TableSlots = 64;
    localparam int PidBits    = 16;

    localparam logic [31:0] KillStatus = 32'hFFFF_FFF7;
    localparam logic [16:0] CpidAny    = 17'h1_FFFF;
    localparam logic [15:0] FirstPid   = 16'd1;
    localparam logic [15:0] NextPidRst = 16'd2;

    typedef enum logic [1:0] {
        OP_FORK = 2'd0,
        OP_EXIT = 2'd1,
        OP_KILL = 2'd2,
        OP_WAIT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_RUN    = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_ZOMBIE = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_FORKED   = 3'd0,
        KIND_EXITED   = 3'd1,
        KIND_BLOCKED  = 3'd2,
        KIND_REAPED   = 3'd3,
        KIND_RELEASED = 3'd4,
        KIND_REJECTED = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN2,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [PidBits-1:0] pid;
        logic [PidBits-1:0] parent;
        t_mode              mode;
        logic [31:0]        status;
        logic [16:0]        pending;
    } t_ent;

    typedef struct packed {
        logic pid_hit;
        logic c_hit;
        logic child;
        logic zchild;
        logic free;
    } t_hit;

    typedef struct packed {
        t_kind              kind;
        logic [PidBits-1:0] subj;
        logic [PidBits-1:0] rpid;
        logic [31:0]        rstat;
        logic               last;
    } t_res;

endpackage

`default_nettype wire

// ----- sv/plte_mem.sv -----
// process table entry memory, one write port and one registered read port
// depends on plte_pkg for the entry type
`default_nettype none

module plte_mem #(
    parameter int TABLE_SLOTS = plte_pkg::TableSlots,
    parameter int IW          = $clog2(TABLE_SLOTS)
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [IW-1:0]  i_waddr,
    input  wire plte_pkg::t_ent i_wdata,
    input  wire logic [IW-1:0]  i_raddr,
    output plte_pkg::t_ent      o_rdata
);

    plte_pkg::t_ent r_mem [TABLE_SLOTS];
    plte_pkg::t_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/plte_match.sv -----
// shared compare unit: classifies one table entry against the current keys
// depends on plte_pkg for the entry and hit types
`default_nettype none

module plte_match (
    input  wire plte_pkg::t_ent                i_ent,
    input  wire logic                          i_used,
    input  wire logic [plte_pkg::PidBits-1:0]  i_key,
    input  wire logic [16:0]                   i_cpid,
    output plte_pkg::t_hit                     o_hit
);

    always_comb begin
        o_hit.pid_hit = i_used && (i_ent.pid == i_key);
        o_hit.c_hit   = i_used && !i_cpid[16] && (i_ent.pid == i_cpid[15:0]);
        o_hit.child   = i_used && (i_ent.parent == i_key);
        o_hit.zchild  = o_hit.child && (i_ent.mode == plte_pkg::MODE_ZOMBIE);
        o_hit.free    = !i_used;
    end

endmodule

`default_nettype wire

// ----- sv/process_table_lifecycle_engine_top.sv -----
// process table lifecycle engine: sequencer, scan registers and result stage
// depends on plte_pkg, plte_mem and plte_match
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_op i_pid i_child_pid i_exit_code
//   result   out        o_valid / i_ready   o_kind o_subject_pid o_reaped_pid
//                                           o_reaped_status o_last
//
// fork, wait: one scan over the table memory read port
// exit, kill: a second scan finds the parent, and a released wait gives a second result
// each result then waits in the output register until taken
// after reset, the init state loads slot 0 before the first transaction
`default_nettype none

module process_table_lifecycle_engine_top #(
    parameter int TABLE_SLOTS = plte_pkg::TableSlots
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic [15:0]        i_pid,
    input  wire logic signed [16:0] i_child_pid,
    input  wire logic signed [31:0] i_exit_code,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_kind,
    output logic [15:0]             o_subject_pid,
    output logic [15:0]             o_reaped_pid,
    output logic signed [31:0]      o_reaped_status,
    output logic                    o_last
);

    localparam int          IW     = $clog2(TABLE_SLOTS);
    localparam logic [IW:0] NSlots = (IW+1)'(TABLE_SLOTS);

    typedef struct packed {
        logic           p_hit;
        logic [IW-1:0]  p_idx;
        plte_pkg::t_ent p_ent;
        logic           c_hit;
        logic [IW-1:0]  c_idx;
        plte_pkg::t_ent c_ent;
        logic           any;
        logic           b_hit;
        logic [IW-1:0]  b_idx;
        plte_pkg::t_ent b_ent;
        logic           f_hit;
        logic [IW-1:0]  f_idx;
        logic           q_hit;
        logic [IW-1:0]  q_idx;
        plte_pkg::t_ent q_ent;
    } t_scan;

    plte_pkg::t_state         r_state, n_state;
    logic [TABLE_SLOTS-1:0]   r_used, n_used;
    logic [IW:0]              r_cnt, n_cnt;
    logic                     r_rvld, n_rvld;
    logic [IW-1:0]            r_ridx, n_ridx;
    t_scan                    r_sc, n_sc;
    plte_pkg::t_op            r_op, n_op;
    logic [15:0]              r_pid, n_pid;
    logic [16:0]              r_cpid, n_cpid;
    logic [31:0]              r_code, n_code;
    logic [15:0]              r_next_id, n_next_id;
    plte_pkg::t_res           r_o, n_o;
    plte_pkg::t_res           r_o2, n_o2;
    logic                     r_two, n_two;

    logic                     w_we;
    logic [IW-1:0]            w_waddr;
    plte_pkg::t_ent           w_wdata;
    plte_pkg::t_ent           w_rdata;
    logic [15:0]              w_key;
    plte_pkg::t_hit           w_hit;
    logic                     w_scan;
    logic                     w_done;
    logic                     w_fin;
    logic [31:0]              w_st;
    plte_pkg::t_res           w_rej;

    plte_mem #(.TABLE_SLOTS(TABLE_SLOTS), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_key = (r_state == plte_pkg::ST_SCAN2) ? r_sc.p_ent.parent : r_pid;

    plte_match u_match (
        .i_ent  (w_rdata),
        .i_used (r_used[r_ridx]),
        .i_key  (w_key),
        .i_cpid (r_cpid),
        .o_hit  (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plte_pkg::ST_INIT;
            r_used    <= TABLE_SLOTS'(1);
            r_cnt     <= '0;
            r_rvld    <= 1'b0;
            r_next_id <= plte_pkg::NextPidRst;
            r_two     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cnt     <= n_cnt;
            r_rvld    <= n_rvld;
            r_next_id <= n_next_id;
            r_two     <= n_two;
        end
        r_ridx <= n_ridx;
        r_sc   <= n_sc;
        r_op   <= n_op;
        r_pid  <= n_pid;
        r_cpid <= n_cpid;
        r_code <= n_code;
        r_o    <= n_o;
        r_o2   <= n_o2;
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_cnt     = r_cnt;
        n_rvld    = 1'b0;
        n_ridx    = r_cnt[IW-1:0];
        n_sc      = r_sc;
        n_op      = r_op;
        n_pid     = r_pid;
        n_cpid    = r_cpid;
        n_code    = r_code;
        n_next_id = r_next_id;
        n_o       = r_o;
        n_o2      = r_o2;
        n_two     = r_two;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_st      = (r_op == plte_pkg::OP_KILL) ? plte_pkg::KillStatus : r_code;
        w_rej     = '{plte_pkg::KIND_REJECTED, r_pid, 16'd0, 32'd0, 1'b1};
        w_scan    = (r_state == plte_pkg::ST_SCAN) || (r_state == plte_pkg::ST_SCAN2);
        w_done    = (r_cnt == NSlots) && !r_rvld;
        w_fin     = 1'b0;

        if (w_scan && (r_cnt < NSlots)) begin
            n_rvld = 1'b1;
            n_cnt  = r_cnt + 1'b1;
        end

        // evaluate the entry read in the previous cycle
        if (r_rvld && r_state == plte_pkg::ST_SCAN) begin
            if (w_hit.pid_hit && !r_sc.p_hit) begin
                n_sc.p_hit = 1'b1;
                n_sc.p_idx = r_ridx;
                n_sc.p_ent = w_rdata;
            end
            if (w_hit.c_hit && !r_sc.c_hit) begin
                n_sc.c_hit = 1'b1;
                n_sc.c_idx = r_ridx;
                n_sc.c_ent = w_rdata;
            end
            if (w_hit.child) begin
                n_sc.any = 1'b1;
            end
            if (w_hit.zchild && (!r_sc.b_hit || w_rdata.pid < r_sc.b_ent.pid)) begin
                n_sc.b_hit = 1'b1;
                n_sc.b_idx = r_ridx;
                n_sc.b_ent = w_rdata;
            end
            if (w_hit.free && !r_sc.f_hit) begin
                n_sc.f_hit = 1'b1;
                n_sc.f_idx = r_ridx;
            end
        end
        if (r_rvld && r_state == plte_pkg::ST_SCAN2) begin
            if (w_hit.pid_hit && !r_sc.q_hit) begin
                n_sc.q_hit = 1'b1;
                n_sc.q_idx = r_ridx;
                n_sc.q_ent = w_rdata;
            end
        end

        unique case (r_state)
            plte_pkg::ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{plte_pkg::FirstPid, 16'd0, plte_pkg::MODE_RUN, 32'd0, 17'd0};
                n_state = plte_pkg::ST_IDLE;
            end
            plte_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_op    = plte_pkg::t_op'(i_op);
                    n_pid   = i_pid;
                    n_cpid  = i_child_pid;
                    n_code  = i_exit_code;
                    n_sc    = '0;
                    n_cnt   = '0;
                    n_state = plte_pkg::ST_SCAN;
                end
            end
            plte_pkg::ST_SCAN: begin
                if (w_done) begin
                    n_cnt = '0;
                    if ((r_op == plte_pkg::OP_EXIT || r_op == plte_pkg::OP_KILL)
                        && r_sc.p_hit && r_sc.p_ent.mode != plte_pkg::MODE_ZOMBIE) begin
                        n_state = plte_pkg::ST_SCAN2;
                    end else begin
                        n_state = plte_pkg::ST_DECIDE;
                    end
                end
            end
            plte_pkg::ST_SCAN2: begin
                if (w_done) begin
                    n_state = plte_pkg::ST_DECIDE;
                end
            end
            plte_pkg::ST_DECIDE: begin
                n_state = plte_pkg::ST_OUT;
                n_two   = 1'b0;
                n_o     = w_rej;
                unique case (r_op)
                    plte_pkg::OP_FORK: begin
                        if (r_sc.p_hit && r_sc.p_ent.mode != plte_pkg::MODE_ZOMBIE
                            && r_next_id != 16'd0 && r_sc.f_hit) begin
                            w_we    = 1'b1;
                            w_waddr = r_sc.f_idx;
                            w_wdata = '{r_next_id, r_pid, plte_pkg::MODE_RUN, 32'd0, 17'd0};
                            n_used[r_sc.f_idx] = 1'b1;
                            n_o       = '{plte_pkg::KIND_FORKED, r_next_id, 16'd0, 32'd0, 1'b1};
                            n_next_id = r_next_id + 16'd1;
                        end
                    end
                    plte_pkg::OP_EXIT, plte_pkg::OP_KILL: begin
                        if (r_sc.p_hit && r_sc.p_ent.mode != plte_pkg::MODE_ZOMBIE) begin
                            if (r_sc.q_hit && r_sc.q_ent.mode == plte_pkg::MODE_WAIT
                                && (r_sc.q_ent.pending == plte_pkg::CpidAny
                                    || r_sc.q_ent.pending == {1'b0, r_pid})) begin
                                w_we    = 1'b1;
                                w_waddr = r_sc.q_idx;
                                w_wdata = r_sc.q_ent;
                                w_wdata.mode = plte_pkg::MODE_RUN;
                                n_used[r_sc.p_idx] = 1'b0;
                                n_o   = '{plte_pkg::KIND_EXITED, r_pid, 16'd0, 32'd0, 1'b0};
                                n_o2  = '{plte_pkg::KIND_REAPED, r_sc.q_ent.pid, r_pid, w_st,
                                          1'b1};
                                n_two = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_sc.p_idx;
                                w_wdata = r_sc.p_ent;
                                w_wdata.mode   = plte_pkg::MODE_ZOMBIE;
                                w_wdata.status = w_st;
                                n_o = '{plte_pkg::KIND_EXITED, r_pid, 16'd0, 32'd0, 1'b1};
                            end
                        end
                    end
                    plte_pkg::OP_WAIT: begin
                        w_fin = 1'b0;
                        if (r_sc.p_hit && r_sc.p_ent.mode == plte_pkg::MODE_RUN) begin
                            if (r_cpid == plte_pkg::CpidAny) begin
                                if (r_sc.any && r_sc.b_hit) begin
                                    n_used[r_sc.b_idx] = 1'b0;
                                    n_o = '{plte_pkg::KIND_REAPED, r_pid, r_sc.b_ent.pid,
                                            r_sc.b_ent.status, 1'b1};
                                end else if (r_sc.any) begin
                                    w_fin = 1'b1;
                                end
                            end else if (r_sc.c_hit && r_sc.c_ent.parent == r_pid) begin
                                if (r_sc.c_ent.mode == plte_pkg::MODE_ZOMBIE) begin
                                    n_used[r_sc.c_idx] = 1'b0;
                                    n_o = '{plte_pkg::KIND_REAPED, r_pid, r_sc.c_ent.pid,
                                            r_sc.c_ent.status, 1'b1};
                                end else begin
                                    w_fin = 1'b1;
                                end
                            end
                        end
                        // park the parent until a matching child exits
                        if (w_fin) begin
                            w_we    = 1'b1;
                            w_waddr = r_sc.p_idx;
                            w_wdata = r_sc.p_ent;
                            w_wdata.mode    = plte_pkg::MODE_WAIT;
                            w_wdata.pending = r_cpid;
                            n_o = '{plte_pkg::KIND_BLOCKED, r_pid, 16'd0, 32'd0, 1'b1};
                        end
                    end
                    default: begin
                        n_o = w_rej;
                    end
                endcase
            end
            plte_pkg::ST_OUT: begin
                if (i_ready) begin
                    if (r_two) begin
                        n_o   = r_o2;
                        n_two = 1'b0;
                    end else begin
                        n_state = plte_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = plte_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ready         = (r_state == plte_pkg::ST_IDLE);
    assign o_valid         = (r_state == plte_pkg::ST_OUT);
    assign o_kind          = r_o.kind;
    assign o_subject_pid   = r_o.subj;
    assign o_reaped_pid    = r_o.rpid;
    assign o_reaped_status = r_o.rstat;
    assign o_last          = r_o.last;

endmodule

`default_nettype wire

// ----- sv/plte_checker.sv -----
// port-level checker for the process table lifecycle engine, bound to the top level
// depends on plte_pkg for the result codes
`default_nettype none

module plte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_kind,
    input wire logic [15:0] o_reaped_pid,
    input wire logic [31:0] o_reaped_status,
    input wire logic        o_last
);

    // no new transaction while a result is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // a non-final result is always the exit that releases a parked wait
    a_first_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == plte_pkg::KIND_EXITED)
        else $error("non-final result is not an exit");

    // the released wait follows right after the exit
    a_second_reap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_last
            && o_kind == plte_pkg::KIND_REAPED)
        else $error("missing reap after exit");

    a_reap_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != plte_pkg::KIND_REAPED |->
            o_reaped_pid == 16'd0 && o_reaped_status == 32'd0)
        else $error("reap fields set on other result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind process_table_lifecycle_engine_top plte_checker u_plte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_reaped_pid    (o_reaped_pid),
    .o_reaped_status (o_reaped_status),
    .o_last          (o_last)
);

`default_nettype wire

// ----- bench/tb_process_table_lifecycle_engine_top.sv -----
// testbench for the process table lifecycle engine: directed and random requests
// checked against a table model in the bench; depends on plte_pkg and the engine
`timescale 1ns / 1ps

module tb_process_table_lifecycle_engine_top;

    localparam int Slots = plte_pkg::TableSlots;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] subj;
        logic [15:0] rpid;
        logic [31:0] rstat;
        logic        last;
    } t_expect;

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    logic [1:0] i_op;
    logic [15:0] i_pid;
    logic signed [16:0] i_child_pid;
    logic signed [31:0] i_exit_code;
    logic [2:0] o_kind;
    logic [15:0] o_subject_pid, o_reaped_pid;
    logic signed [31:0] o_reaped_status;
    logic o_last;

    process_table_lifecycle_engine_top uut (.*);

    // bench copy of the table
    logic               tbl_used [Slots];
    logic [15:0]        tbl_pid [Slots];
    logic [15:0]        tbl_parent [Slots];
    plte_pkg::t_mode    tbl_mode [Slots];
    logic [31:0]        tbl_status [Slots];
    logic signed [16:0] tbl_pend [Slots];
    logic [15:0]        pid_next;

    t_expect expected_q[$];
    int errors = 0, results_seen = 0, items_sent = 0;
    int send_idle = 0, recv_stall = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int find_pid(logic [15:0] p);
        for (int i = 0; i < Slots; i++) if (tbl_used[i] && tbl_pid[i] == p) return i;
        return -1;
    endfunction

    function automatic void push_res(plte_pkg::t_kind k, logic [15:0] s, logic [15:0] rp,
                                     logic [31:0] rs, logic l);
        t_expect e;
        e.kind = k; e.subj = s; e.rpid = rp; e.rstat = rs; e.last = l;
        expected_q.push_back(e);
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < Slots; i++) begin
            tbl_used[i] = 1'b0; tbl_pid[i] = 16'd0; tbl_parent[i] = 16'd0;
            tbl_mode[i] = plte_pkg::MODE_RUN; tbl_status[i] = 32'd0; tbl_pend[i] = 17'sd0;
        end
        tbl_used[0] = 1'b1; tbl_pid[0] = plte_pkg::FirstPid; pid_next = plte_pkg::NextPidRst;
    endfunction

    function automatic void predict_request(plte_pkg::t_op op, logic [15:0] pid,
                                            logic signed [16:0] cp, logic [31:0] code);
        int p, s, q, best, c;
        logic any;
        logic [31:0] st;
        p = find_pid(pid);
        s = -1; best = -1; any = 1'b0;
        case (op)
            plte_pkg::OP_FORK: begin
                for (int i = Slots - 1; i >= 0; i--) if (!tbl_used[i]) s = i;
                if (p < 0 || tbl_mode[p] == plte_pkg::MODE_ZOMBIE || pid_next == 16'd0
                    || s < 0) begin
                    push_res(plte_pkg::KIND_REJECTED, pid, 16'd0, 32'd0, 1'b1);
                end else begin
                    tbl_used[s] = 1'b1; tbl_pid[s] = pid_next; tbl_parent[s] = pid;
                    tbl_mode[s] = plte_pkg::MODE_RUN;
                    push_res(plte_pkg::KIND_FORKED, pid_next, 16'd0, 32'd0, 1'b1);
                    pid_next = pid_next + 16'd1;
                end
            end
            plte_pkg::OP_EXIT, plte_pkg::OP_KILL: begin
                st = (op == plte_pkg::OP_KILL) ? plte_pkg::KillStatus : code;
                if (p < 0 || tbl_mode[p] == plte_pkg::MODE_ZOMBIE) begin
                    push_res(plte_pkg::KIND_REJECTED, pid, 16'd0, 32'd0, 1'b1);
                end else begin
                    tbl_mode[p] = plte_pkg::MODE_ZOMBIE; tbl_status[p] = st;
                    q = find_pid(tbl_parent[p]);
                    if (q >= 0 && tbl_mode[q] == plte_pkg::MODE_WAIT &&
                        (tbl_pend[q] == -1 || (tbl_pend[q] >= 0 && tbl_pend[q] == pid))) begin
                        push_res(plte_pkg::KIND_EXITED, pid, 16'd0, 32'd0, 1'b0);
                        tbl_mode[q] = plte_pkg::MODE_RUN;
                        tbl_used[p] = 1'b0; tbl_mode[p] = plte_pkg::MODE_RUN;
                        push_res(plte_pkg::KIND_REAPED, tbl_pid[q], pid, st, 1'b1);
                    end else begin
                        push_res(plte_pkg::KIND_EXITED, pid, 16'd0, 32'd0, 1'b1);
                    end
                end
            end
            default: begin
                if (p < 0 || tbl_mode[p] != plte_pkg::MODE_RUN) begin
                    push_res(plte_pkg::KIND_REJECTED, pid, 16'd0, 32'd0, 1'b1);
                    return;
                end
                if (cp == -1) begin
                    for (int i = 0; i < Slots; i++) begin
                        if (!tbl_used[i] || tbl_parent[i] != pid) continue;
                        any = 1'b1;
                        if (tbl_mode[i] == plte_pkg::MODE_ZOMBIE &&
                            (best < 0 || tbl_pid[i] < tbl_pid[best])) best = i;
                    end
                    if (!any) begin
                        push_res(plte_pkg::KIND_REJECTED, pid, 16'd0, 32'd0, 1'b1);
                        return;
                    end
                end else begin
                    c = (cp >= 0) ? find_pid(cp[15:0]) : -1;
                    if (c < 0 || tbl_parent[c] != pid) begin
                        push_res(plte_pkg::KIND_REJECTED, pid, 16'd0, 32'd0, 1'b1);
                        return;
                    end
                    if (tbl_mode[c] == plte_pkg::MODE_ZOMBIE) best = c;
                end
                if (best >= 0) begin
                    tbl_used[best] = 1'b0; tbl_mode[best] = plte_pkg::MODE_RUN;
                    push_res(plte_pkg::KIND_REAPED, pid, tbl_pid[best], tbl_status[best], 1'b1);
                end else begin
                    tbl_mode[p] = plte_pkg::MODE_WAIT; tbl_pend[p] = cp;
                    push_res(plte_pkg::KIND_BLOCKED, pid, 16'd0, 32'd0, 1'b1);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
    endtask

    // valid stays up between back to back transactions and drops only while idling
    task automatic send_request(plte_pkg::t_op op, logic [15:0] pid, logic signed [16:0] cp,
                                logic [31:0] code);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1; i_op <= op; i_pid <= pid; i_child_pid <= cp; i_exit_code <= code;
        do @(posedge i_clk); while (!o_ready);
        predict_request(op, pid, cp, code);
        items_sent++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_kind), 32'd0);
            end else begin
                e = expected_q.pop_front();
                if (o_kind !== e.kind) report_mismatch("kind", 32'(o_kind), 32'(e.kind));
                if (o_subject_pid !== e.subj)
                    report_mismatch("subject_pid", 32'(o_subject_pid), 32'(e.subj));
                if (o_reaped_pid !== e.rpid)
                    report_mismatch("reaped_pid", 32'(o_reaped_pid), 32'(e.rpid));
                if (o_reaped_status !== e.rstat)
                    report_mismatch("reaped_status", o_reaped_status, e.rstat);
                if (o_last !== e.last) report_mismatch("last", 32'(o_last), 32'(e.last));
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    // pick a pid that is likely live
    function automatic logic [15:0] some_pid();
        int k;
        k = $urandom_range(Slots - 1);
        for (int i = 0; i < Slots; i++)
            if (tbl_used[(k + i) % Slots]) return tbl_pid[(k + i) % Slots];
        return plte_pkg::FirstPid;
    endfunction

    function automatic logic signed [16:0] some_child(logic [15:0] par);
        int k;
        k = $urandom_range(Slots - 1);
        for (int i = 0; i < Slots; i++)
            if (tbl_used[(k + i) % Slots] && tbl_parent[(k + i) % Slots] == par)
                return {1'b0, tbl_pid[(k + i) % Slots]};
        return plte_pkg::CpidAny;
    endfunction

    task automatic test_directed();
        send_request(plte_pkg::OP_WAIT, 16'd1, plte_pkg::CpidAny, 32'd0);   // childless wait
        send_request(plte_pkg::OP_FORK, 16'd1, 17'sd0, 32'd0);              // pid 2
        send_request(plte_pkg::OP_FORK, 16'hFFFF, 17'sd0, 32'd0);           // unknown
        send_request(plte_pkg::OP_FORK, 16'd2, 17'sd0, 32'd0);             // pid 3, child of 2
        send_request(plte_pkg::OP_EXIT, 16'd2, 17'sd0, 32'h8000_0000);
        send_request(plte_pkg::OP_FORK, 16'd2, 17'sd0, 32'd0);              // zombie forks
        send_request(plte_pkg::OP_EXIT, 16'd2, 17'sd0, 32'd0);              // zombie exits
        send_request(plte_pkg::OP_WAIT, 16'd1, 17'sd3, 32'd0);              // foreign child
        send_request(plte_pkg::OP_WAIT, 16'd1, -17'sd2, 32'd0);             // negative not any
        send_request(plte_pkg::OP_WAIT, 16'd1, plte_pkg::CpidAny, 32'd0);   // reap 2
        send_request(plte_pkg::OP_FORK, 16'd1, 17'sd0, 32'd0);              // pid 4
        send_request(plte_pkg::OP_WAIT, 16'd1, 17'sd4, 32'd0);              // blocked
        send_request(plte_pkg::OP_WAIT, 16'd1, plte_pkg::CpidAny, 32'd0);   // second wait
        send_request(plte_pkg::OP_EXIT, 16'd4, 17'sd0, 32'h7FFF_FFFF);      // releases wait
        send_request(plte_pkg::OP_FORK, 16'd1, 17'sd0, 32'd0);              // pid 5
        send_request(plte_pkg::OP_WAIT, 16'd1, plte_pkg::CpidAny, 32'd0);
        send_request(plte_pkg::OP_KILL, 16'd5, 17'sd0, 32'h1234);           // kill releases
        send_request(plte_pkg::OP_FORK, 16'd3, 17'sd0, 32'd0);              // pid 6
        send_request(plte_pkg::OP_WAIT, 16'd3, plte_pkg::CpidAny, 32'd0);
        send_request(plte_pkg::OP_KILL, 16'd3, 17'sd0, 32'd0);              // waiter exits
        send_request(plte_pkg::OP_EXIT, 16'd6, 17'sd0, 32'hFFFF_FFFF);
        send_request(plte_pkg::OP_WAIT, 16'd3, plte_pkg::CpidAny, 32'd0);   // zombie waits
        send_request(plte_pkg::OP_WAIT, 16'h0, 17'h0_FFFF, 32'd0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < Slots + 2; i++)
            send_request(plte_pkg::OP_FORK, 16'd1, 17'sd0, $urandom);
        for (int i = 0; i < Slots; i++) begin
            send_request(plte_pkg::OP_KILL, some_pid(), 17'sd0, 32'd0);
            send_request(plte_pkg::OP_WAIT, some_pid(), plte_pkg::CpidAny, 32'd0);
        end
    endtask

    task automatic test_random(int n);
        logic [15:0] p;
        logic signed [16:0] c;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            p = (r < 90) ? some_pid() : 16'($urandom);
            c = ($urandom_range(2) == 0) ? plte_pkg::CpidAny : some_child(p);
            if ($urandom_range(19) == 0) c = 17'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3: send_request(plte_pkg::OP_FORK, p, 17'($urandom), $urandom);
                4, 5:       send_request(plte_pkg::OP_EXIT, p, 17'($urandom), $urandom);
                6:          send_request(plte_pkg::OP_KILL, p, 17'($urandom), $urandom);
                default:    send_request(plte_pkg::OP_WAIT, p, c, $urandom);
            endcase
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * Slots + 20) @(posedge i_clk);
    endtask

    initial begin
        i_valid = 0; i_op = 0; i_pid = 0; i_child_pid = 0; i_exit_code = 0; i_ready = 1;
        i_rst_n = 0;
        table_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_full_table();
        test_random(400);
        send_idle = 86; test_random(350);
        send_idle = 0; recv_stall = 86; test_random(350);
        send_idle = 6; recv_stall = 6; test_random(350);
        send_idle = 0; recv_stall = 0;
        drain();
        $display("covered %0d requests and %0d results, incl. a full table and stall phases",
                 items_sent, results_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- files.f -----
sv/plte_pkg.sv
sv/plte_mem.sv
sv/plte_match.sv
sv/process_table_lifecycle_engine_top.sv
sv/plte_checker.sv
bench/tb_process_table_lifecycle_engine_top.sv
